// ===== rtl/core/cfr_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 function for the
// CRC-32 frame receiver. No dependencies.
package cfr_pkg;

    localparam int IDX_W = 13;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC
    } cfr_phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_SYNC,
        ST_TOO_LONG,
        ST_CRC_ERR,
        ST_TRUNCATED
    } cfr_status_t;

    typedef enum logic [1:0] {
        ACT_PASS,
        ACT_PING,
        ACT_RESET
    } cfr_action_t;

    localparam logic [1:0] REG_SYNC  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_PING  = 2'd2;
    localparam logic [1:0] REG_RESET = 2'd3;

    localparam logic [15:0] SYNC_RST  = 16'h0000;
    localparam logic [12:0] LIMIT_RST = 13'd4096;
    localparam logic [7:0]  PING_RST  = 8'd1;
    localparam logic [7:0]  RESET_RST = 8'd2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] sync_pattern;
        logic [12:0] payload_limit;
        logic [7:0]  ping_code;
        logic [7:0]  reset_code;
    } cfr_cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        cfr_status_t status;
        logic [15:0] sequence_res;
        logic [15:0] length;
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [31:0] frame_crc;
        cfr_action_t control_action;
        logic [15:0] next_rx_sequence;
    } cfr_result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc32_frame_receiver.sv =====
// CRC-32 frame receiver: one received byte per transaction in, payload bytes and
// end-of-frame reports out. Each result is formed combinationally and registered
// in the output buffer. Throughput is one byte per cycle, set by the byte-wide
// CRC update in the parser. Input is held off only while both result buffer
// entries wait on the output. Reset (rst_n low, asynchronous) returns to hunting,
// clears the expected sequence and loads the register defaults.
module crc32_frame_receiver #(
    parameter int MAX_PAYLOAD = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tuser,   // [0] frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] data_byte, [10:8] status, [26:11] sequence_res, [42:27] length,
    // [50:43] frame_type, [58:51] frame_flags, [90:59] frame_crc,
    // [92:91] control_action, [108:93] next_rx_sequence, [111:109] zero
    output logic [111:0] m_tdata,
    output logic         m_tuser,   // [0] kind
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfr_pkg::cfr_cfg_t    cfg;
    cfr_pkg::cfr_result_t res;
    cfr_pkg::cfr_result_t out_res;
    logic                 res_valid;
    logic                 space;
    logic                 in_accept;

    assign s_tready  = space;
    assign in_accept = s_tvalid & s_tready;

    cfr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    cfr_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {3'b000,
                      out_res.next_rx_sequence,
                      out_res.control_action,
                      out_res.frame_crc,
                      out_res.frame_flags,
                      out_res.frame_type,
                      out_res.length,
                      out_res.sequence_res,
                      out_res.status,
                      out_res.data_byte};

endmodule

// ===== rtl/core/cfr_apb_regs.sv =====
// APB configuration registers of the CRC-32 frame receiver.
// Depends on cfr_pkg for register indexes, reset values and the config struct.
module cfr_apb_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfr_pkg::cfr_cfg_t cfg
);

    cfr_pkg::cfr_cfg_t cfg_reg;
    cfr_pkg::cfr_cfg_t cfg_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                cfr_pkg::REG_SYNC:  cfg_next.sync_pattern  = pwdata[15:0];
                cfr_pkg::REG_LIMIT: cfg_next.payload_limit = pwdata[12:0];
                cfr_pkg::REG_PING:  cfg_next.ping_code     = pwdata[7:0];
                cfr_pkg::REG_RESET: cfg_next.reset_code    = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            cfr_pkg::REG_SYNC:  prdata = {16'h0, cfg_reg.sync_pattern};
            cfr_pkg::REG_LIMIT: prdata = {19'h0, cfg_reg.payload_limit};
            cfr_pkg::REG_PING:  prdata = {24'h0, cfg_reg.ping_code};
            cfr_pkg::REG_RESET: prdata = {24'h0, cfg_reg.reset_code};
            default:            prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_pattern  <= cfr_pkg::SYNC_RST;
            cfg_reg.payload_limit <= cfr_pkg::LIMIT_RST;
            cfg_reg.ping_code     <= cfr_pkg::PING_RST;
            cfg_reg.reset_code    <= cfr_pkg::RESET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/cfr_parser.sv =====
// Frame parser of the CRC-32 frame receiver: header capture, CRC update and
// frame checks, one byte per cycle while in_accept is high. Depends on cfr_pkg.
module cfr_parser #(
    parameter int MAX_PAYLOAD = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_start,
    input  cfr_pkg::cfr_cfg_t    cfg,
    output logic                 res_valid,
    output cfr_pkg::cfr_result_t res
);

    localparam logic [15:0] MaxPay = 16'(MAX_PAYLOAD);
    localparam logic [cfr_pkg::IDX_W-1:0] IdxSyncLo = cfr_pkg::IDX_W'(1);
    localparam logic [cfr_pkg::IDX_W-1:0] IdxSeqHi  = cfr_pkg::IDX_W'(2);
    localparam logic [cfr_pkg::IDX_W-1:0] IdxSeqLo  = cfr_pkg::IDX_W'(3);
    localparam logic [cfr_pkg::IDX_W-1:0] IdxLenHi  = cfr_pkg::IDX_W'(4);
    localparam logic [cfr_pkg::IDX_W-1:0] IdxLenLo  = cfr_pkg::IDX_W'(5);
    localparam logic [cfr_pkg::IDX_W-1:0] IdxType   = cfr_pkg::IDX_W'(6);

    cfr_pkg::cfr_phase_t         phase_reg, phase_next;
    logic [cfr_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [31:0]                 crc_acc_reg, crc_acc_next;
    logic [31:0]                 crc_rx_reg, crc_rx_next;
    logic [7:0]                  sync_hi_reg, sync_hi_next;
    logic                        sync_bad_reg, sync_bad_next;
    logic [15:0]                 seq_reg, seq_next;
    logic [15:0]                 len_reg, len_next;
    logic [7:0]                  type_reg, type_next;
    logic [7:0]                  flags_reg, flags_next;
    logic [15:0]                 exp_seq_reg, exp_seq_next;
    logic [15:0]                 limit;
    logic [15:0]                 idx_inc;
    logic [31:0]                 crc_upd;

    assign limit   = ({3'b0, cfg.payload_limit} > MaxPay) ? MaxPay : {3'b0, cfg.payload_limit};
    assign idx_inc = 16'(idx_reg) + 16'd1;
    assign crc_upd = cfr_pkg::crc_byte(crc_acc_reg, rx_byte);

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        crc_acc_next = crc_acc_reg;
        crc_rx_next  = crc_rx_reg;
        sync_hi_next = sync_hi_reg;
        sync_bad_next = sync_bad_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        flags_next   = flags_reg;
        exp_seq_next = exp_seq_reg;
        res_valid    = 1'b0;
        res.kind             = 1'b0;
        res.data_byte        = 8'h0;
        res.status           = cfr_pkg::ST_OK;
        res.sequence_res     = seq_reg;
        res.length           = len_reg;
        res.frame_type       = type_reg;
        res.frame_flags      = flags_reg;
        res.frame_crc        = 32'h0;
        res.control_action   = cfr_pkg::ACT_PASS;
        res.next_rx_sequence = exp_seq_reg;

        if (in_accept)
        begin
            if (frame_start)
            begin
                if (phase_reg != cfr_pkg::PH_HUNT)
                begin
                    res_valid  = 1'b1;
                    res.kind   = 1'b1;
                    res.status = cfr_pkg::ST_TRUNCATED;
                end
                phase_next    = cfr_pkg::PH_HEADER;
                idx_next      = IdxSyncLo;
                crc_acc_next  = cfr_pkg::crc_byte(cfr_pkg::CRC_INIT, rx_byte);
                crc_rx_next   = 32'h0;
                sync_hi_next  = rx_byte;
                sync_bad_next = 1'b0;
                seq_next      = 16'h0;
                len_next      = 16'h0;
                type_next     = 8'h0;
                flags_next    = 8'h0;
            end
            else
            begin
                case (phase_reg)
                    cfr_pkg::PH_HEADER:
                    begin
                        crc_acc_next = crc_upd;
                        idx_next     = idx_inc[cfr_pkg::IDX_W-1:0];
                        case (idx_reg)
                            IdxSyncLo: sync_bad_next = ({sync_hi_reg, rx_byte} != cfg.sync_pattern);
                            IdxSeqHi:  seq_next  = {rx_byte, 8'h0};
                            IdxSeqLo:  seq_next  = {seq_reg[15:8], rx_byte};
                            IdxLenHi:  len_next  = {rx_byte, 8'h0};
                            IdxLenLo:  len_next  = {len_reg[15:8], rx_byte};
                            IdxType:   type_next = rx_byte;
                            default:
                            begin
                                flags_next      = rx_byte;
                                res.frame_flags = rx_byte;
                                idx_next        = '0;
                                if (sync_bad_reg)
                                begin
                                    phase_next = cfr_pkg::PH_HUNT;
                                    idx_next   = idx_reg;
                                    res_valid  = 1'b1;
                                    res.kind   = 1'b1;
                                    res.status = cfr_pkg::ST_BAD_SYNC;
                                end
                                else if (len_reg > limit)
                                begin
                                    phase_next = cfr_pkg::PH_HUNT;
                                    idx_next   = idx_reg;
                                    res_valid  = 1'b1;
                                    res.kind   = 1'b1;
                                    res.status = cfr_pkg::ST_TOO_LONG;
                                end
                                else if (len_reg == 16'h0)
                                begin
                                    phase_next = cfr_pkg::PH_CRC;
                                end
                                else
                                begin
                                    phase_next = cfr_pkg::PH_PAYLOAD;
                                end
                            end
                        endcase
                    end
                    cfr_pkg::PH_PAYLOAD:
                    begin
                        crc_acc_next = crc_upd;
                        idx_next     = idx_inc[cfr_pkg::IDX_W-1:0];
                        if (idx_inc >= len_reg)
                        begin
                            idx_next   = '0;
                            phase_next = cfr_pkg::PH_CRC;
                        end
                        res_valid     = 1'b1;
                        res.data_byte = rx_byte;
                    end
                    cfr_pkg::PH_CRC:
                    begin
                        crc_rx_next = crc_rx_reg | ({24'h0, rx_byte} << {idx_reg[1:0], 3'b000});
                        idx_next    = idx_inc[cfr_pkg::IDX_W-1:0];
                        if (idx_reg[1:0] == 2'd3)
                        begin
                            phase_next    = cfr_pkg::PH_HUNT;
                            idx_next      = '0;
                            res_valid     = 1'b1;
                            res.kind      = 1'b1;
                            res.frame_crc = crc_rx_next;
                            if (crc_rx_next != ~crc_acc_reg)
                            begin
                                res.status = cfr_pkg::ST_CRC_ERR;
                            end
                            else
                            begin
                                exp_seq_next = seq_reg + 16'd1;
                                if (type_reg == cfg.ping_code)
                                begin
                                    res.control_action = cfr_pkg::ACT_PING;
                                end
                                else if (type_reg == cfg.reset_code)
                                begin
                                    res.control_action = cfr_pkg::ACT_RESET;
                                    exp_seq_next       = 16'h0;
                                end
                                res.next_rx_sequence = exp_seq_next;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= cfr_pkg::PH_HUNT;
            idx_reg      <= '0;
            crc_acc_reg  <= cfr_pkg::CRC_INIT;
            crc_rx_reg   <= 32'h0;
            sync_hi_reg  <= 8'h0;
            sync_bad_reg <= 1'b0;
            seq_reg      <= 16'h0;
            len_reg      <= 16'h0;
            type_reg     <= 8'h0;
            flags_reg    <= 8'h0;
            exp_seq_reg  <= 16'h0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            crc_acc_reg  <= crc_acc_next;
            crc_rx_reg   <= crc_rx_next;
            sync_hi_reg  <= sync_hi_next;
            sync_bad_reg <= sync_bad_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            type_reg     <= type_next;
            flags_reg    <= flags_next;
            exp_seq_reg  <= exp_seq_next;
        end
    end

    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !frame_start && phase_reg == cfr_pkg::PH_HUNT) |-> !res_valid)
        else $error("result produced while hunting");

    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.kind) |-> (res.status == cfr_pkg::ST_OK
            && res.control_action == cfr_pkg::ACT_PASS))
        else $error("payload result with report fields set");

    a_action_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.control_action != cfr_pkg::ACT_PASS) |-> (res.status == cfr_pkg::ST_OK))
        else $error("control action on a failed frame");

endmodule

// ===== rtl/core/cfr_out_buf.sv =====
// Two-entry result buffer that decouples the parser from the output stream.
// Depends on cfr_pkg for the result struct.
module cfr_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cfr_pkg::cfr_result_t push_data,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cfr_pkg::cfr_result_t out_data
);

    cfr_pkg::cfr_result_t entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2 || pop))
        else $error("push into a full buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("buffer count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("buffer pointers disagree with count");

endmodule
